// ===== hw/rtl/cri_pkg.sv =====
// Shared types, constants and helpers for the chunk region iterator.
package cri_pkg;

   localparam int NDIM       = 3;
   localparam int COORD_W    = 24;
   localparam int SIZE_W     = 16;
   localparam int STRIDE_W   = 24;
   localparam int CUR_W      = COORD_W + 2;   // cursor keeps two bits past the coordinate
   localparam int END_W      = COORD_W + 1;
   localparam int CE_W       = CUR_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int DIV_CNT_W  = $clog2(CUR_W);

   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [SIZE_W-1:0]     size_type;
   typedef logic [STRIDE_W-1:0]   stride_type;
   typedef logic [CUR_W-1:0]      cur_type;
   typedef logic [END_W-1:0]      end_type;
   typedef logic [CE_W-1:0]       ce_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [DIV_CNT_W-1:0]  div_cnt_type;

   localparam csr_idx_type CSR_SIZE_0   = 3'd0;
   localparam csr_idx_type CSR_SIZE_1   = 3'd1;
   localparam csr_idx_type CSR_SIZE_2   = 3'd2;
   localparam csr_idx_type CSR_STRIDE_0 = 3'd3;
   localparam csr_idx_type CSR_STRIDE_1 = 3'd4;
   localparam csr_idx_type CSR_STRIDE_2 = 3'd5;

   localparam logic MODE_BEGIN   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   typedef struct packed {
      logic      mode;
      coord_type region_start_0;
      coord_type region_start_1;
      coord_type region_start_2;
      coord_type region_count_0;
      coord_type region_count_1;
      coord_type region_count_2;
   } req_item_type;

   typedef struct packed {
      coord_type chunk_origin_0;
      coord_type chunk_origin_1;
      coord_type chunk_origin_2;
      coord_type chunk_index;
      coord_type overlap_start_0;
      coord_type overlap_start_1;
      coord_type overlap_start_2;
      size_type  overlap_len_0;
      size_type  overlap_len_1;
      size_type  overlap_len_2;
      logic      in_region;
   } rsp_item_type;

   typedef struct packed {
      logic     go;
      cur_type  dividend;
      size_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      cur_type  quotient;
      size_type remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BGO,
      ST_BDIV,
      ST_BMUL,
      ST_CHECK,
      ST_AGO,
      ST_ADIV,
      ST_QGO,
      ST_QDIV,
      ST_WMUL,
      ST_EMIT
   } state_type;

   // a zero chunk size behaves as size one
   function automatic size_type eff_size(input size_type s);
      return (s == '0) ? size_type'(1) : s;
   endfunction

endpackage

// ===== hw/rtl/cri_req_if.sv =====
// Request channel: valid/ready handshake carrying one iterator command item.
interface cri_req_if;
   logic                  valid;
   logic                  ready;
   cri_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cri_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one chunk descriptor item.
interface cri_rsp_if;
   logic                  valid;
   logic                  ready;
   cri_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cri_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module cri_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cri_pkg::div_req_type div_req,
   output cri_pkg::div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   cri_pkg::div_cnt_type cnt_ff, cnt_in;
   cri_pkg::cur_type     quo_ff, quo_in;
   cri_pkg::size_type    rem_ff, rem_in;
   cri_pkg::size_type    dvs_ff, dvs_in;

   logic [cri_pkg::SIZE_W:0] shifted_w;
   logic [cri_pkg::SIZE_W:0] diff_w;
   logic                     fits_w;

   assign shifted_w = {rem_ff, quo_ff[cri_pkg::CUR_W-1]};
   assign diff_w    = shifted_w - {1'b0, dvs_ff};
   assign fits_w    = shifted_w >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits_w ? diff_w[cri_pkg::SIZE_W-1:0] : shifted_w[cri_pkg::SIZE_W-1:0];
         quo_in = {quo_ff[cri_pkg::CUR_W-2:0], fits_w};
         if (cnt_ff == cri_pkg::div_cnt_type'(cri_pkg::CUR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== hw/rtl/cri_mul.sv =====
// Shared stride multiplier, product kept modulo the index width and registered.
module cri_mul (
   input  logic                 clock,
   input  cri_pkg::stride_type  mul_a,
   input  cri_pkg::coord_type   mul_b,
   output cri_pkg::coord_type   mul_prod
);

   logic [cri_pkg::STRIDE_W+cri_pkg::COORD_W-1:0] full_w;
   cri_pkg::coord_type                            prod_ff, prod_in;

   assign full_w  = mul_a * mul_b;
   assign prod_in = full_w[cri_pkg::COORD_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

// ===== hw/rtl/chunk_region_iterator_unit.sv =====
// Chunk region iterator: walks the chunks of a 3-D chunked array touched by a box region.
//
// Channels: req_ch takes one command item (begin a region or advance), rsp_ch returns
// one chunk descriptor per command: chunk origin, linear chunk index, overlap of chunk
// and region, and the in_region flag. The csr_* port writes chunk sizes and strides; the
// user must write it only while the block is idle, which the block itself does not enforce.
// One command is worked on at a time; req_ch.ready is high only between commands and
// the next item is taken the cycle after a result is loaded, so an advance is not taken
// before the result of the last command is loaded.
// Steps: an advance moves the innermost dimension on and checks it; a carry out of the
// innermost dimension adds a stride multiply and a check of the next, a further carry
// into the outermost adds a stride multiply, and each carry also realigns with two
// divisions on the shared divider if that dimension's chunk size was rewritten since
// the region began; a begin runs, per dimension, a load, a 26-step division, a finish
// and a stride multiply.
// A finished descriptor sits in an output register; the next command is accepted while
// it waits, and the block stalls before writing the following result until it is taken.
// Reset (synchronous) sets sizes and strides to 1 and clears the region, so an advance
// before any begin returns all zeros with in_region low.
module chunk_region_iterator_unit (
   input  logic                      clock,
   input  logic                      reset,
   cri_req_if.sink                   req_ch,
   cri_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  cri_pkg::csr_idx_type      csr_index,
   input  cri_pkg::csr_data_type     csr_wdata
);

   localparam int ND = cri_pkg::NDIM;

   cri_pkg::state_type    state_ff, state_in;
   cri_pkg::size_type     size_ff   [ND], size_in   [ND];
   cri_pkg::stride_type   stride_ff [ND], stride_in [ND];
   cri_pkg::cur_type      cur_ff    [ND], cur_in    [ND];
   cri_pkg::coord_type    start_ff  [ND], start_in  [ND];
   cri_pkg::coord_type    count_ff  [ND], count_in  [ND];
   cri_pkg::coord_type    align_ff  [1:2], align_in [1:2];
   cri_pkg::coord_type    step_ff   [1:2], step_in  [1:2];
   logic [2:1]            fresh_ff, fresh_in;
   cri_pkg::coord_type    li_ff, li_in;
   logic [1:0]            bd_ff, bd_in;
   logic                  wsel_ff, wsel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cri_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   cri_pkg::size_type     eff_w [ND];
   cri_pkg::end_type      end_w [ND];
   cri_pkg::ce_type       ce_w  [ND];
   cri_pkg::cur_type      os_w  [ND];
   cri_pkg::ce_type       oe_w  [ND];
   cri_pkg::size_type     len_w [ND];
   cri_pkg::rsp_item_type emit_w;

   // inner = dimension under carry check, outer = the one it carries into
   cri_pkg::cur_type      in_cur;
   cri_pkg::end_type      in_end;
   cri_pkg::coord_type    in_start, in_align, in_step;
   cri_pkg::size_type     in_eff;
   cri_pkg::stride_type   in_stride, out_stride;
   logic                  in_fresh;
   logic                  in_past_end;
   cri_pkg::coord_type    b_start;
   cri_pkg::size_type     b_eff;
   cri_pkg::stride_type   b_stride;
   cri_pkg::coord_type    b_align;
   logic                  wrap_now;

   cri_pkg::div_req_type  div_req;
   cri_pkg::div_rsp_type  div_rsp;
   cri_pkg::stride_type   mul_a;
   cri_pkg::coord_type    mul_b;
   cri_pkg::coord_type    mul_prod;

   cri_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   cri_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   always_comb begin
      for (int d = 0; d < ND; d++) begin
         eff_w[d] = cri_pkg::eff_size(size_ff[d]);
         end_w[d] = cri_pkg::end_type'(start_ff[d]) + cri_pkg::end_type'(count_ff[d]);
         ce_w[d]  = cri_pkg::ce_type'(cur_ff[d]) + cri_pkg::ce_type'(eff_w[d]);
         os_w[d]  = (cri_pkg::cur_type'(start_ff[d]) > cur_ff[d]) ?
                    cri_pkg::cur_type'(start_ff[d]) : cur_ff[d];
         oe_w[d]  = (cri_pkg::ce_type'(end_w[d]) < ce_w[d]) ?
                    cri_pkg::ce_type'(end_w[d]) : ce_w[d];
         len_w[d] = (oe_w[d] > cri_pkg::ce_type'(os_w[d])) ?
                    cri_pkg::size_type'(oe_w[d] - cri_pkg::ce_type'(os_w[d])) : '0;
      end
   end

   always_comb begin
      emit_w.chunk_origin_0  = cur_ff[0][cri_pkg::COORD_W-1:0];
      emit_w.chunk_origin_1  = cur_ff[1][cri_pkg::COORD_W-1:0];
      emit_w.chunk_origin_2  = cur_ff[2][cri_pkg::COORD_W-1:0];
      emit_w.chunk_index     = li_ff;
      emit_w.overlap_start_0 = os_w[0][cri_pkg::COORD_W-1:0];
      emit_w.overlap_start_1 = os_w[1][cri_pkg::COORD_W-1:0];
      emit_w.overlap_start_2 = os_w[2][cri_pkg::COORD_W-1:0];
      emit_w.overlap_len_0   = len_w[0];
      emit_w.overlap_len_1   = len_w[1];
      emit_w.overlap_len_2   = len_w[2];
      emit_w.in_region       = cur_ff[0] < cri_pkg::cur_type'(end_w[0]);
   end

   assign in_cur     = wsel_ff ? cur_ff[2]    : cur_ff[1];
   assign in_end     = wsel_ff ? end_w[2]     : end_w[1];
   assign in_start   = wsel_ff ? start_ff[2]  : start_ff[1];
   assign in_align   = wsel_ff ? align_ff[2]  : align_ff[1];
   assign in_step    = wsel_ff ? step_ff[2]   : step_ff[1];
   assign in_eff     = wsel_ff ? eff_w[2]     : eff_w[1];
   assign in_stride  = wsel_ff ? stride_ff[2] : stride_ff[1];
   assign in_fresh   = wsel_ff ? fresh_ff[2]  : fresh_ff[1];
   assign out_stride = wsel_ff ? stride_ff[1] : stride_ff[0];
   assign in_past_end = in_cur >= cri_pkg::cur_type'(in_end);

   always_comb begin
      case (bd_ff)
         2'd0: begin
            b_start  = start_ff[0];
            b_eff    = eff_w[0];
            b_stride = stride_ff[0];
         end
         2'd1: begin
            b_start  = start_ff[1];
            b_eff    = eff_w[1];
            b_stride = stride_ff[1];
         end
         default: begin
            b_start  = start_ff[2];
            b_eff    = eff_w[2];
            b_stride = stride_ff[2];
         end
      endcase
   end

   assign b_align = b_start - cri_pkg::coord_type'(div_rsp.remainder);

   always_comb begin
      div_req.go = (state_ff == cri_pkg::ST_BGO) || (state_ff == cri_pkg::ST_AGO) ||
                   (state_ff == cri_pkg::ST_QGO);
      if (state_ff == cri_pkg::ST_BGO) begin
         div_req.dividend = cri_pkg::cur_type'(b_start);
         div_req.divisor  = b_eff;
      end else if (state_ff == cri_pkg::ST_AGO) begin
         div_req.dividend = cri_pkg::cur_type'(in_start);
         div_req.divisor  = in_eff;
      end else begin
         div_req.dividend = in_cur - cri_pkg::cur_type'(in_align);
         div_req.divisor  = in_eff;
      end
   end

   assign mul_a = (state_ff == cri_pkg::ST_BDIV) ? b_stride : in_stride;
   assign mul_b = ((state_ff == cri_pkg::ST_BDIV) || (state_ff == cri_pkg::ST_QDIV)) ?
                  div_rsp.quotient[cri_pkg::COORD_W-1:0] : in_step;

   // carry out of the inner dimension: fast when its alignment is still current
   assign wrap_now = ((state_ff == cri_pkg::ST_CHECK) && in_past_end && in_fresh) ||
                     ((state_ff == cri_pkg::ST_QDIV) && div_rsp.done);

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      stride_in    = stride_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      align_in     = align_ff;
      step_in      = step_ff;
      fresh_in     = fresh_ff;
      li_in        = li_ff;
      bd_in        = bd_ff;
      wsel_in      = wsel_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (csr_we) begin
         unique case (csr_index)
            cri_pkg::CSR_SIZE_0: size_in[0] = csr_wdata[cri_pkg::SIZE_W-1:0];
            cri_pkg::CSR_SIZE_1: begin
               size_in[1]  = csr_wdata[cri_pkg::SIZE_W-1:0];
               fresh_in[1] = 1'b0;
            end
            cri_pkg::CSR_SIZE_2: begin
               size_in[2]  = csr_wdata[cri_pkg::SIZE_W-1:0];
               fresh_in[2] = 1'b0;
            end
            cri_pkg::CSR_STRIDE_0: stride_in[0] = csr_wdata[cri_pkg::STRIDE_W-1:0];
            cri_pkg::CSR_STRIDE_1: stride_in[1] = csr_wdata[cri_pkg::STRIDE_W-1:0];
            cri_pkg::CSR_STRIDE_2: stride_in[2] = csr_wdata[cri_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         cri_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.data.mode == cri_pkg::MODE_BEGIN) begin
                  start_in[0] = req_ch.data.region_start_0;
                  start_in[1] = req_ch.data.region_start_1;
                  start_in[2] = req_ch.data.region_start_2;
                  count_in[0] = req_ch.data.region_count_0;
                  count_in[1] = req_ch.data.region_count_1;
                  count_in[2] = req_ch.data.region_count_2;
                  li_in       = '0;
                  bd_in       = '0;
                  state_in    = cri_pkg::ST_BGO;
               end else if (emit_w.in_region) begin
                  cur_in[2]  = cur_ff[2] + cri_pkg::cur_type'(eff_w[2]);
                  step_in[2] = step_ff[2] + 1'b1;
                  li_in      = li_ff + stride_ff[2];
                  wsel_in    = 1'b1;
                  state_in   = cri_pkg::ST_CHECK;
               end else begin
                  state_in = cri_pkg::ST_EMIT;
               end
            end
         end
         cri_pkg::ST_BGO: state_in = cri_pkg::ST_BDIV;
         cri_pkg::ST_BDIV: begin
            if (div_rsp.done) begin
               case (bd_ff)
                  2'd0: cur_in[0] = cri_pkg::cur_type'(b_align);
                  2'd1: begin
                     cur_in[1]   = cri_pkg::cur_type'(b_align);
                     align_in[1] = b_align;
                     step_in[1]  = '0;
                     fresh_in[1] = 1'b1;
                  end
                  default: begin
                     cur_in[2]   = cri_pkg::cur_type'(b_align);
                     align_in[2] = b_align;
                     step_in[2]  = '0;
                     fresh_in[2] = 1'b1;
                  end
               endcase
               state_in = cri_pkg::ST_BMUL;
            end
         end
         cri_pkg::ST_BMUL: begin
            li_in = li_ff + mul_prod;
            if (bd_ff == 2'(ND - 1)) begin
               state_in = cri_pkg::ST_EMIT;
            end else begin
               bd_in    = bd_ff + 1'b1;
               state_in = cri_pkg::ST_BGO;
            end
         end
         cri_pkg::ST_CHECK: begin
            if (!in_past_end) begin
               state_in = cri_pkg::ST_EMIT;
            end else if (in_fresh) begin
               state_in = cri_pkg::ST_WMUL;
            end else begin
               state_in = cri_pkg::ST_AGO;
            end
         end
         cri_pkg::ST_AGO: state_in = cri_pkg::ST_ADIV;
         cri_pkg::ST_ADIV: begin
            if (div_rsp.done) begin
               if (wsel_ff) begin
                  align_in[2] = in_start - cri_pkg::coord_type'(div_rsp.remainder);
                  fresh_in[2] = 1'b1;
               end else begin
                  align_in[1] = in_start - cri_pkg::coord_type'(div_rsp.remainder);
                  fresh_in[1] = 1'b1;
               end
               state_in = cri_pkg::ST_QGO;
            end
         end
         cri_pkg::ST_QGO: state_in = cri_pkg::ST_QDIV;
         cri_pkg::ST_QDIV: begin
            if (div_rsp.done) begin
               state_in = cri_pkg::ST_WMUL;
            end
         end
         cri_pkg::ST_WMUL: begin
            li_in = li_ff + out_stride - mul_prod;
            if (wsel_ff) begin
               wsel_in  = 1'b0;
               state_in = cri_pkg::ST_CHECK;
            end else begin
               state_in = cri_pkg::ST_EMIT;
            end
         end
         cri_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = emit_w;
               state_in     = cri_pkg::ST_IDLE;
            end
         end
         default: state_in = cri_pkg::ST_IDLE;
      endcase

      if (wrap_now) begin
         if (wsel_ff) begin
            cur_in[2]  = cri_pkg::cur_type'(align_ff[2]);
            step_in[2] = '0;
            cur_in[1]  = cur_ff[1] + cri_pkg::cur_type'(eff_w[1]);
            step_in[1] = step_ff[1] + 1'b1;
         end else begin
            cur_in[1]  = cri_pkg::cur_type'(align_ff[1]);
            step_in[1] = '0;
            cur_in[0]  = cur_ff[0] + cri_pkg::cur_type'(eff_w[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cri_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= '0;
         li_ff        <= '0;
         bd_ff        <= '0;
         wsel_ff      <= 1'b0;
         for (int d = 0; d < ND; d++) begin
            size_ff[d]   <= cri_pkg::size_type'(1);
            stride_ff[d] <= cri_pkg::stride_type'(1);
            cur_ff[d]    <= '0;
            start_ff[d]  <= '0;
            count_ff[d]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= fresh_in;
         li_ff        <= li_in;
         bd_ff        <= bd_in;
         wsel_ff      <= wsel_in;
         size_ff      <= size_in;
         stride_ff    <= stride_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
      end
      align_ff    <= align_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ch.ready = (state_ff == cri_pkg::ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

// ===== hw/rtl/cri_checker.sv =====
// Port-level checks for the chunk region iterator, bound to the top level.
module cri_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input cri_pkg::rsp_item_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result item changed while stalled");

   // one command at a time: the block is busy right after taking an item
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while busy");

   // a fresh result is written only as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while still busy");

endmodule

bind chunk_region_iterator_unit cri_checker u_cri_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
